### hw/rtl/quadratic_root_solver_defines.svh
// Assertion macros for the quadratic root solver.
// Both macros sample on the rising edge of clk_i and are off during reset.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`ifndef SYNTH
`define QRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qrs assertion failed");
`define QRS_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("qrs forbidden condition seen");
`else
`define QRS_ASSERT(lbl, prop)
`define QRS_ASSERT_NEVER(lbl, prop)
`endif
`endif

### hw/rtl/qrs_pkg.sv
package qrs_pkg;

  // Width of each root on the result channel.
  localparam int ROOT_W = 34;

  // Classification of the equation.
  typedef enum logic [2:0] {
    CASE_INDET  = 3'd0,
    CASE_IMPOSS = 3'd1,
    CASE_LINEAR = 3'd2,
    CASE_NONE   = 3'd3,
    CASE_DOUBLE = 3'd4,
    CASE_TWO    = 3'd5
  } case_e;

endpackage

### hw/rtl/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
module qrs_sqrt_cell #(
  parameter int RAD_W  = 8,
  parameter int RT_W   = 4,
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [RT_W-1:0]   root_i,
  input  logic [RT_W:0]     rem_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [RT_W-1:0]   root_o,
  output logic [RT_W:0]     rem_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int Pos = RAD_W - 2 - 2 * IDX;

  logic              vld_q;
  logic [RAD_W-1:0]  rad_q;
  logic [RT_W-1:0]   root_q, root_d;
  logic [RT_W:0]     rem_q, rem_d;
  logic [SIDE_W-1:0] side_q;
  logic [RT_W+2:0]   rem_sh, trial, diff;
  logic              fit;

  // Bring down the next pair of radicand bits and try the new root bit.
  always_comb begin
    rem_sh = {rem_i, rad_i[Pos +: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = rem_sh - trial;
    fit    = (rem_sh >= trial);
    rem_d  = fit ? diff[RT_W:0] : rem_sh[RT_W:0];
    root_d = {root_i[RT_W-2:0], fit};
  end

  // Valid bit of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Data held by the cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i;
      root_q <= root_d;
      rem_q  <= rem_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign side_o = side_q;

endmodule

### hw/rtl/qrs_div_cell.sv
// One cell of the divider chain: settles one quotient bit for both
// numerators, which share the divisor.
module qrs_div_cell #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 4,
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num1_i,
  input  logic [NUM_W-1:0]  num2_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [NUM_W-1:0]  quo1_i,
  input  logic [NUM_W-1:0]  quo2_i,
  input  logic [DEN_W-1:0]  rem1_i,
  input  logic [DEN_W-1:0]  rem2_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NUM_W-1:0]  num1_o,
  output logic [NUM_W-1:0]  num2_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [NUM_W-1:0]  quo1_o,
  output logic [NUM_W-1:0]  quo2_o,
  output logic [DEN_W-1:0]  rem1_o,
  output logic [DEN_W-1:0]  rem2_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int Pos = NUM_W - 1 - IDX;

  logic              vld_q;
  logic [NUM_W-1:0]  num1_q, num2_q, quo1_q, quo2_q, quo1_d, quo2_d;
  logic [DEN_W-1:0]  den_q, rem1_q, rem2_q, rem1_d, rem2_d;
  logic [SIDE_W-1:0] side_q;
  logic [DEN_W:0]    rs1, rs2, df1, df2, den_x;
  logic              ge1, ge2;

  // Shift in the next numerator bit and subtract the divisor where it fits.
  always_comb begin
    den_x  = {1'b0, den_i};
    rs1    = {rem1_i, num1_i[Pos]};
    rs2    = {rem2_i, num2_i[Pos]};
    df1    = rs1 - den_x;
    df2    = rs2 - den_x;
    ge1    = (rs1 >= den_x);
    ge2    = (rs2 >= den_x);
    rem1_d = ge1 ? df1[DEN_W-1:0] : rs1[DEN_W-1:0];
    rem2_d = ge2 ? df2[DEN_W-1:0] : rs2[DEN_W-1:0];
    quo1_d = {quo1_i[NUM_W-2:0], ge1};
    quo2_d = {quo2_i[NUM_W-2:0], ge2};
  end

  // Valid bit of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Data held by the cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= num1_i;
      num2_q <= num2_i;
      den_q  <= den_i;
      quo1_q <= quo1_d;
      quo2_q <= quo2_d;
      rem1_q <= rem1_d;
      rem2_q <= rem2_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign num1_o = num1_q;
  assign num2_o = num2_q;
  assign den_o  = den_q;
  assign quo1_o = quo1_q;
  assign quo2_o = quo2_q;
  assign rem1_o = rem1_q;
  assign rem2_o = rem2_q;
  assign side_o = side_q;

endmodule

### hw/rtl/quadratic_root_solver.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   coef_quad_i, coef_lin_i, coef_const_i
// out       output     out_valid_o / out_stall_i case_code_o, root_first_o, root_second_o
//
// One equation is taken per cycle and one result leaves per cycle, except while
// in_stall_o or out_stall_i holds the flow. The pipeline has SW = COEF_WIDTH +
// FRAC_BITS + 1 square root cells (one root bit each) and NM = COEF_WIDTH +
// FRAC_BITS + 2 divider cells (one quotient bit each).
// Reset clears every valid bit; data registers are not reset.
// A result that meets a stalled output goes to a skid register; while the skid
// register is full, in_stall_o is high and the whole pipeline holds.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [COEF_WIDTH-1:0]        coef_quad_i,
  input  logic [COEF_WIDTH-1:0]        coef_lin_i,
  input  logic [COEF_WIDTH-1:0]        coef_const_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   case_code_o,
  output logic [qrs_pkg::ROOT_W-1:0]   root_first_o,
  output logic [qrs_pkg::ROOT_W-1:0]   root_second_o
);

  localparam int CW  = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * CW;
  localparam int DW  = 2 * CW + 3;
  localparam int SW  = CW + F + 1;
  localparam int RW  = 2 * SW;
  localparam int NW  = CW + F + 3;
  localparam int NM  = NW - 1;
  localparam int DVW = CW + 1;
  localparam int SQS = 3 + 3 * CW;
  localparam int DVS = 5;
  localparam int RTW = qrs_pkg::ROOT_W;
  localparam int EW  = ((NM > RTW) ? NM : RTW) + 1;

  localparam logic signed [EW-1:0] RMax = (EW'(1) << (RTW - 1)) - EW'(1);
  localparam logic signed [EW-1:0] RMin = -RMax - EW'(1);

  logic en;

  // Turn a quotient magnitude and sign into a saturated root.
  function automatic logic [RTW-1:0] sat_root(input logic [NM-1:0] q, input logic neg);
    logic signed [EW-1:0] v;
    logic signed [EW-1:0] r;
    begin
      v = neg ? -$signed(EW'(q)) : $signed(EW'(q));
      if (v > RMax) begin
        r = RMax;
      end else if (v < RMin) begin
        r = RMin;
      end else begin
        r = v;
      end
      sat_root = r[RTW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- stage 1
  logic                   s1_vld_q;
  logic signed [CW-1:0]   s1_a_q, s1_b_q, s1_c_q;
  logic signed [PW-1:0]   s1_bb_q, s1_ac_q, bb_d, ac_d;
  logic signed [CW-1:0]   a_in, b_in, c_in;

  // Products b*b and a*c.
  always_comb begin
    a_in = $signed(coef_quad_i);
    b_in = $signed(coef_lin_i);
    c_in = $signed(coef_const_i);
    bb_d = b_in * b_in;
    ac_d = a_in * c_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q  <= a_in;
      s1_b_q  <= b_in;
      s1_c_q  <= c_in;
      s1_bb_q <= bb_d;
      s1_ac_q <= ac_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                 s2_vld_q;
  logic [RW-1:0]        s2_rad_q, rad_d;
  logic [SQS-1:0]       s2_side_q;
  logic signed [DW-1:0] disc;
  qrs_pkg::case_e       code_d;

  // Discriminant, classification and radicand.
  always_comb begin
    disc = DW'(s1_bb_q) - (DW'(s1_ac_q) <<< 2);
    if (s1_a_q == '0) begin
      if (s1_b_q == '0) begin
        code_d = (s1_c_q == '0) ? qrs_pkg::CASE_INDET : qrs_pkg::CASE_IMPOSS;
      end else begin
        code_d = qrs_pkg::CASE_LINEAR;
      end
    end else if (disc < 0) begin
      code_d = qrs_pkg::CASE_NONE;
    end else if (disc == '0) begin
      code_d = qrs_pkg::CASE_DOUBLE;
    end else begin
      code_d = qrs_pkg::CASE_TWO;
    end
    if (code_d == qrs_pkg::CASE_TWO) begin
      rad_d = RW'(disc[2*CW:0]) << (2 * F);
    end else begin
      rad_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rad_q  <= rad_d;
      s2_side_q <= {code_d, s1_a_q, s1_b_q, s1_c_q};
    end
  end

  // ------------------------------------------------------ square root chain
  logic           sq_vld  [0:SW];
  logic [RW-1:0]  sq_rad  [0:SW];
  logic [SW-1:0]  sq_root [0:SW];
  logic [SW:0]    sq_rem  [0:SW];
  logic [SQS-1:0] sq_side [0:SW];

  assign sq_vld[0]  = s2_vld_q;
  assign sq_rad[0]  = s2_rad_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = s2_side_q;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(
      .RAD_W (RW),
      .RT_W  (SW),
      .IDX   (k),
      .SIDE_W(SQS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (sq_vld[k]),
      .rad_i (sq_rad[k]),
      .root_i(sq_root[k]),
      .rem_i (sq_rem[k]),
      .side_i(sq_side[k]),
      .vld_o (sq_vld[k+1]),
      .rad_o (sq_rad[k+1]),
      .root_o(sq_root[k+1]),
      .rem_o (sq_rem[k+1]),
      .side_o(sq_side[k+1])
    );
  end

  // --------------------------------------------------- divider preparation
  logic                  p_vld_q;
  logic [NM-1:0]         p_n1_q, p_n2_q, n1m, n2m;
  logic [DVW-1:0]        p_den_q, denm;
  logic [DVS-1:0]        p_side_q;
  logic [2:0]            sq_code;
  logic signed [CW-1:0]  sq_a, sq_b, sq_c;
  logic signed [NW-1:0]  nb, nc, sx, n1, n2;
  logic signed [CW+1:0]  den;
  logic                  neg1, neg2;

  // Numerators and divisor for the case at hand, as sign and magnitude.
  always_comb begin
    sq_code = sq_side[SW][SQS-1 -: 3];
    sq_a    = $signed(sq_side[SW][3*CW-1 -: CW]);
    sq_b    = $signed(sq_side[SW][2*CW-1 -: CW]);
    sq_c    = $signed(sq_side[SW][CW-1:0]);
    nb      = -(NW'(sq_b) <<< F);
    nc      = -(NW'(sq_c) <<< F);
    sx      = $signed(NW'(sq_root[SW]));
    case (qrs_pkg::case_e'(sq_code))
      qrs_pkg::CASE_LINEAR: begin
        n1  = nc;
        n2  = '0;
        den = (CW+2)'(sq_b);
      end
      qrs_pkg::CASE_DOUBLE: begin
        n1  = nb;
        n2  = nb;
        den = (CW+2)'(sq_a) <<< 1;
      end
      qrs_pkg::CASE_TWO: begin
        n1  = nb + sx;
        n2  = nb - sx;
        den = (CW+2)'(sq_a) <<< 1;
      end
      default: begin
        n1  = '0;
        n2  = '0;
        den = (CW+2)'(1);
      end
    endcase
    n1m  = n1[NW-1] ? NM'(-n1) : NM'(n1);
    n2m  = n2[NW-1] ? NM'(-n2) : NM'(n2);
    denm = den[CW+1] ? DVW'(-den) : DVW'(den);
    neg1 = n1[NW-1] ^ den[CW+1];
    neg2 = n2[NW-1] ^ den[CW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= sq_vld[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_n1_q   <= n1m;
      p_n2_q   <= n2m;
      p_den_q  <= denm;
      p_side_q <= {sq_code, neg1, neg2};
    end
  end

  // ---------------------------------------------------------- divider chain
  logic           dv_vld  [0:NM];
  logic [NM-1:0]  dv_n1   [0:NM];
  logic [NM-1:0]  dv_n2   [0:NM];
  logic [DVW-1:0] dv_den  [0:NM];
  logic [NM-1:0]  dv_q1   [0:NM];
  logic [NM-1:0]  dv_q2   [0:NM];
  logic [DVW-1:0] dv_r1   [0:NM];
  logic [DVW-1:0] dv_r2   [0:NM];
  logic [DVS-1:0] dv_side [0:NM];

  assign dv_vld[0]  = p_vld_q;
  assign dv_n1[0]   = p_n1_q;
  assign dv_n2[0]   = p_n2_q;
  assign dv_den[0]  = p_den_q;
  assign dv_q1[0]   = '0;
  assign dv_q2[0]   = '0;
  assign dv_r1[0]   = '0;
  assign dv_r2[0]   = '0;
  assign dv_side[0] = p_side_q;

  for (genvar k = 0; k < NM; k++) begin : g_div
    qrs_div_cell #(
      .NUM_W (NM),
      .DEN_W (DVW),
      .IDX   (k),
      .SIDE_W(DVS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (dv_vld[k]),
      .num1_i(dv_n1[k]),
      .num2_i(dv_n2[k]),
      .den_i (dv_den[k]),
      .quo1_i(dv_q1[k]),
      .quo2_i(dv_q2[k]),
      .rem1_i(dv_r1[k]),
      .rem2_i(dv_r2[k]),
      .side_i(dv_side[k]),
      .vld_o (dv_vld[k+1]),
      .num1_o(dv_n1[k+1]),
      .num2_o(dv_n2[k+1]),
      .den_o (dv_den[k+1]),
      .quo1_o(dv_q1[k+1]),
      .quo2_o(dv_q2[k+1]),
      .rem1_o(dv_r1[k+1]),
      .rem2_o(dv_r2[k+1]),
      .side_o(dv_side[k+1])
    );
  end

  // ------------------------------------------------------------ final stage
  logic             l_vld_q;
  logic [2:0]       l_code_q, fin_code;
  logic [RTW-1:0]   l_r1_q, l_r2_q, fin_r1, fin_r2;

  // Apply signs, saturate and zero the roots that the case does not have.
  always_comb begin
    fin_code = dv_side[NM][4:2];
    fin_r1   = sat_root(dv_q1[NM], dv_side[NM][1]);
    fin_r2   = sat_root(dv_q2[NM], dv_side[NM][0]);
    case (qrs_pkg::case_e'(fin_code))
      qrs_pkg::CASE_LINEAR: begin
        fin_r2 = '0;
      end
      qrs_pkg::CASE_DOUBLE, qrs_pkg::CASE_TWO: begin
      end
      default: begin
        fin_r1 = '0;
        fin_r2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_vld_q <= 1'b0;
    end else if (en) begin
      l_vld_q <= dv_vld[NM];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_code_q <= fin_code;
      l_r1_q   <= fin_r1;
      l_r2_q   <= fin_r2;
    end
  end

  // ------------------------------------------------- output and skid stage
  logic           o_vld_q, k_vld_q, take;
  logic [2:0]     o_code_q, k_code_q;
  logic [RTW-1:0] o_r1_q, o_r2_q, k_r1_q, k_r2_q;

  assign en   = !k_vld_q;
  assign take = o_vld_q && !out_stall_i;

  // The skid register fills only when the output holds a result that is
  // not transferred in this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
      k_vld_q <= 1'b0;
    end else if (k_vld_q) begin
      if (take) begin
        k_vld_q <= 1'b0;
      end
    end else if (!o_vld_q || take) begin
      o_vld_q <= l_vld_q;
    end else if (l_vld_q) begin
      k_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (k_vld_q) begin
      if (take) begin
        o_code_q <= k_code_q;
        o_r1_q   <= k_r1_q;
        o_r2_q   <= k_r2_q;
      end
    end else if (!o_vld_q || take) begin
      o_code_q <= l_code_q;
      o_r1_q   <= l_r1_q;
      o_r2_q   <= l_r2_q;
    end else begin
      k_code_q <= l_code_q;
      k_r1_q   <= l_r1_q;
      k_r2_q   <= l_r2_q;
    end
  end

  assign in_stall_o    = k_vld_q;
  assign out_valid_o   = o_vld_q;
  assign case_code_o   = o_code_q;
  assign root_first_o  = o_r1_q;
  assign root_second_o = o_r2_q;

  // ------------------------------------------------------------ assertions
  `QRS_ASSERT(a_skid_behind_out, k_vld_q |-> o_vld_q)
  `QRS_ASSERT(a_skid_fill, $rose(k_vld_q) |-> $past(o_vld_q && out_stall_i))
  `QRS_ASSERT(a_double_same, (o_vld_q && o_code_q == qrs_pkg::CASE_DOUBLE) |-> (o_r1_q == o_r2_q))
  `QRS_ASSERT_NEVER(a_rootless_nonzero, o_vld_q && o_code_q != qrs_pkg::CASE_LINEAR && o_code_q != qrs_pkg::CASE_DOUBLE && o_code_q != qrs_pkg::CASE_TWO && (o_r1_q != '0 || o_r2_q != '0))

endmodule
